>>> sv/fcpa_pkg.sv
// Shared types, constants and codes of the fixed chunk pool allocator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fcpa_pkg;

  // Sizing of the pool and of the address path.
  localparam int unsigned MaxChunks  = 256;
  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned CountWidth = $clog2(MaxChunks + 1);
  localparam int unsigned IdxWidth   = $clog2(MaxChunks);
  localparam int unsigned SizeWidth  = 16;
  localparam int unsigned DivWidth   = SizeWidth;
  localparam int unsigned DivCntWidth = $clog2(DivWidth);
  localparam int unsigned ProdWidth  = IdxWidth + SizeWidth;

  // Operation codes carried in the mode field.
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_POOL_SIZE  = 2'd1,
    CFG_CHUNK_SIZE = 2'd2
  } cfg_idx_e;

  // Which operands feed the shared divider.
  typedef enum logic [1:0] {
    DIV_COUNT = 2'd0,
    DIV_SIZE  = 2'd1,
    DIV_INDEX = 2'd2
  } div_sel_e;

  // Kind of result word to present.
  typedef enum logic [1:0] {
    EMIT_FAIL    = 2'd0,
    EMIT_ALLOC   = 2'd1,
    EMIT_RELEASE = 2'd2
  } emit_e;

  typedef struct packed {
    logic                 mode;
    logic [AddrWidth-1:0] chunk_address;
  } cmd_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  result_address;
    logic                  granted;
    logic [CountWidth-1:0] free_count;
    logic [CountWidth-1:0] min_free_ever;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     cfg_we;
    logic     cmd_ld;
    logic     div_start;
    div_sel_e div_sel;
    logic     ld_total;
    logic     ld_eff;
    logic     ld_span;
    logic     pop;
    logic     mul;
    logic     push;
    logic     emit;
    emit_e    emit_kind;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic top_zero;
    logic rel_ok;
    logic div_done;
    logic rem_zero;
  } dp_stat_t;

endpackage

>>> sv/fixed_chunk_pool_allocator_top.sv
// Top level of the fixed chunk pool allocator: controller plus datapath.
// Depends on fcpa_pkg, fcpa_ctrl, fcpa_dp and fcpa_div.

// The block hands out and takes back equal chunks of a byte pool. Raise
// start_i with a command word on cmd_i while busy_o is low; mode 0 pops the
// most recently freed chunk and returns its address, mode 1 gives back the
// chunk at chunk_address. Exactly one result word comes back per command,
// on res_o for a single cycle with done_o high; there is no way to hold it
// off, so the receiver must take it in that cycle. An allocate goes
// through the free list memory read and the index times chunk size
// multiply before its result word is registered. A release waits on the
// shared divider, which works out the chunk index and checks the
// alignment one quotient bit per cycle over sixteen bits; a release that
// is off a chunk boundary returns after the division without a push, and
// one failing its range check skips the division. The next command may be
// started in the cycle the result word is shown. Configuration goes through
// the cfg_valid_i / cfg_ready_o channel with the register index on
// cfg_index_i (0 pool base, 1 pool size, 2 chunk size; index 3 is taken
// and ignored). Every write to a known register rebuilds the pool: two
// divisions and a span multiply, during which busy_o is high and no command
// or further write is taken. After reset the pool is
// empty, so every allocate fails until the pool is configured.
module fixed_chunk_pool_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  fcpa_pkg::cmd_t                  cmd_i,
  output logic                            done_o,
  output fcpa_pkg::res_t                  res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [fcpa_pkg::AddrWidth-1:0]  cfg_wdata_i
);

  fcpa_pkg::ctrl_cmd_t ctl;
  fcpa_pkg::dp_stat_t  stat;

  // The controller sequences configuration rebuilds, allocates and releases.
  fcpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .mode_i      (cmd_i.mode),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .stat_i      (stat),
    .busy_o      (busy_o),
    .cfg_ready_o (cfg_ready_o),
    .ctl_o       (ctl)
  );

  // The datapath holds the registers, the free list and the divider, and
  // drives the registered result word.
  fcpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .res_o       (res_o),
    .done_o      (done_o)
  );

endmodule

>>> sv/fcpa_div.sv
// Restoring divider, one quotient bit per cycle, for the chunk pool allocator.
// Depends on fcpa_pkg for its widths.
module fcpa_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [fcpa_pkg::DivWidth-1:0]   dividend_i,
  input  logic [fcpa_pkg::DivWidth-1:0]   divisor_i,
  output logic                            done_o,
  output logic [fcpa_pkg::DivWidth-1:0]   quotient_o,
  output logic [fcpa_pkg::DivWidth-1:0]   remainder_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [fcpa_pkg::DivCntWidth-1:0]   cnt_q, cnt_d;
  logic [fcpa_pkg::DivWidth-1:0]      quo_q, quo_d;
  logic [fcpa_pkg::DivWidth-1:0]      rem_q, rem_d;
  logic [fcpa_pkg::DivWidth-1:0]      den_q, den_d;
  logic [fcpa_pkg::DivWidth:0]        trial;
  logic [fcpa_pkg::DivWidth:0]        diff;

  assign trial = {rem_q, quo_q[fcpa_pkg::DivWidth-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      // A set top bit of the difference means the trial did not fit.
      if (!diff[fcpa_pkg::DivWidth]) begin
        rem_d = diff[fcpa_pkg::DivWidth-1:0];
        quo_d = {quo_q[fcpa_pkg::DivWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[fcpa_pkg::DivWidth-1:0];
        quo_d = {quo_q[fcpa_pkg::DivWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == fcpa_pkg::DivCntWidth'(fcpa_pkg::DivWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // A new division must never be started over one still in progress.
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  // Completion is reported only at the end of a running division.
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

>>> sv/fcpa_dp.sv
// Datapath of the chunk pool allocator: configuration, counters, free list
// memory, address arithmetic and result register. Depends on fcpa_pkg and fcpa_div.
module fcpa_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        cfg_index_i,
  input  logic [fcpa_pkg::AddrWidth-1:0]    cfg_wdata_i,
  input  fcpa_pkg::cmd_t                    cmd_i,
  input  fcpa_pkg::ctrl_cmd_t               ctl_i,
  output fcpa_pkg::dp_stat_t                stat_o,
  output fcpa_pkg::res_t                    res_o,
  output logic                              done_o
);

  localparam int unsigned CW = fcpa_pkg::CountWidth;
  localparam int unsigned IW = fcpa_pkg::IdxWidth;
  localparam int unsigned SW = fcpa_pkg::SizeWidth;
  localparam int unsigned AW = fcpa_pkg::AddrWidth;
  localparam int unsigned PW = fcpa_pkg::ProdWidth;

  // Configuration and pool geometry.
  logic [AW-1:0]  base_q;
  logic [SW-1:0]  size_q, chunk_q;
  logic [CW-1:0]  total_q, total_d;
  logic [SW-1:0]  eff_q, eff_d;
  logic [SW-1:0]  span_q;
  logic [CW+SW-1:0] span_full;

  // Free list state.
  logic [CW-1:0]  top_q, low_q;
  logic [CW-1:0]  pos;
  logic [IW-1:0]  mem [fcpa_pkg::MaxChunks];
  logic [IW-1:0]  rd_q, pos_q, idx;
  logic           hit_q;
  logic [PW-1:0]  prod_q;

  // Latched command word and result register.
  fcpa_pkg::cmd_t cmd_q;
  fcpa_pkg::res_t res_q;
  logic           done_q;

  // Divider operands and results.
  logic [SW-1:0]  div_a, div_b, quo, rem;
  logic           div_done;
  logic [AW-1:0]  offset;

  fcpa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ctl_i.div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign offset = cmd_q.chunk_address - base_q;

  always_comb begin
    unique case (ctl_i.div_sel)
      fcpa_pkg::DIV_COUNT: begin
        div_a = size_q;
        div_b = chunk_q;
      end
      fcpa_pkg::DIV_SIZE: begin
        div_a = size_q;
        div_b = SW'(total_q);
      end
      fcpa_pkg::DIV_INDEX: begin
        div_a = offset[SW-1:0];
        div_b = eff_q;
      end
      default: begin
        div_a = size_q;
        div_b = chunk_q;
      end
    endcase
  end

  // Chunk count saturates at the pool limit; a zero chunk size gives no pool.
  always_comb begin
    if (chunk_q == '0) begin
      total_d = '0;
    end else if (quo > SW'(fcpa_pkg::MaxChunks)) begin
      total_d = CW'(fcpa_pkg::MaxChunks);
    end else begin
      total_d = quo[CW-1:0];
    end
    eff_d = (total_q == '0) ? '0 : quo;
  end

  assign span_full = total_q * eff_q;
  assign pos       = top_q - 1'b1;
  assign idx       = hit_q ? rd_q : pos_q;

  assign stat_o.div_done = div_done;
  assign stat_o.top_zero = (top_q == '0);
  assign stat_o.rem_zero = (rem == '0);
  assign stat_o.rel_ok   = (eff_q != '0) && (cmd_q.chunk_address >= base_q) &&
                           (offset < AW'(span_q)) && (top_q < total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      size_q  <= '0;
      chunk_q <= SW'(1);
      total_q <= '0;
      eff_q   <= '0;
      span_q  <= '0;
      top_q   <= '0;
      low_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctl_i.emit;
      if (ctl_i.cfg_we) begin
        unique case (cfg_index_i)
          fcpa_pkg::CFG_POOL_BASE:  base_q  <= cfg_wdata_i;
          fcpa_pkg::CFG_POOL_SIZE:  size_q  <= cfg_wdata_i[SW-1:0];
          fcpa_pkg::CFG_CHUNK_SIZE: chunk_q <= cfg_wdata_i[SW-1:0];
          default: ;
        endcase
      end
      if (ctl_i.ld_total) begin
        total_q <= total_d;
        top_q   <= total_d;
        low_q   <= total_d;
      end
      if (ctl_i.ld_eff) begin
        eff_q <= eff_d;
      end
      if (ctl_i.ld_span) begin
        span_q <= span_full[SW-1:0];
      end
      if (ctl_i.pop) begin
        top_q <= pos;
        if (low_q > pos) begin
          low_q <= pos;
        end
      end
      if (ctl_i.push) begin
        top_q <= top_q + 1'b1;
      end
    end
  end

  // Entries below the low-water mark have not been written since the pool
  // was rebuilt, so a pop there takes the entry's own position as chunk index.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[top_q[IW-1:0]] <= quo[IW-1:0];
    end
    if (ctl_i.pop) begin
      rd_q  <= mem[pos[IW-1:0]];
      pos_q <= pos[IW-1:0];
      hit_q <= (pos >= low_q);
    end
    if (ctl_i.mul) begin
      prod_q <= idx * eff_q;
    end
    if (ctl_i.cmd_ld) begin
      cmd_q <= cmd_i;
    end
    if (ctl_i.emit) begin
      res_q.free_count    <= top_q;
      res_q.min_free_ever <= low_q;
      case (ctl_i.emit_kind)
        fcpa_pkg::EMIT_ALLOC: begin
          res_q.result_address <= base_q + AW'(prod_q);
          res_q.granted        <= 1'b1;
        end
        fcpa_pkg::EMIT_RELEASE: begin
          res_q.result_address <= '0;
          res_q.granted        <= 1'b1;
        end
        default: begin
          res_q.result_address <= '0;
          res_q.granted        <= 1'b0;
        end
      endcase
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

  a_top_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= total_q)
    else $error("free count exceeds chunk total");

  a_low_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= top_q)
    else $error("low-water mark above free count");

  a_total_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(fcpa_pkg::MaxChunks))
    else $error("chunk total above pool limit");

  a_single_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("two result words in a row");

endmodule

>>> sv/fcpa_ctrl.sv
// Controller state machine of the chunk pool allocator.
// Depends on fcpa_pkg for its command and status types.
module fcpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  mode_i,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  fcpa_pkg::dp_stat_t    stat_i,
  output logic                  busy_o,
  output logic                  cfg_ready_o,
  output fcpa_pkg::ctrl_cmd_t   ctl_o
);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_CFG_DIV_N  = 13'b0000000000010,
    S_CFG_WAIT_N = 13'b0000000000100,
    S_CFG_DIV_E  = 13'b0000000001000,
    S_CFG_WAIT_E = 13'b0000000010000,
    S_CFG_SPAN   = 13'b0000000100000,
    S_ALLOC_POP  = 13'b0000001000000,
    S_ALLOC_MUL  = 13'b0000010000000,
    S_ALLOC_OUT  = 13'b0000100000000,
    S_REL_CHK    = 13'b0001000000000,
    S_REL_WAIT   = 13'b0010000000000,
    S_REL_PUSH   = 13'b0100000000000,
    S_REL_OUT    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   idle, cfg_acc, cfg_known;

  assign idle        = (state_q == S_IDLE);
  assign cfg_ready_o = idle && !start_i;
  assign busy_o      = !idle;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_known   = (cfg_index_i == fcpa_pkg::CFG_POOL_BASE) ||
                       (cfg_index_i == fcpa_pkg::CFG_POOL_SIZE) ||
                       (cfg_index_i == fcpa_pkg::CFG_CHUNK_SIZE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.cmd_ld = 1'b1;
          state_d = (mode_i == fcpa_pkg::MODE_RELEASE) ? S_REL_CHK : S_ALLOC_POP;
        end else if (cfg_acc && cfg_known) begin
          ctl_o.cfg_we = 1'b1;
          state_d = S_CFG_DIV_N;
        end
      end
      S_CFG_DIV_N: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_sel   = fcpa_pkg::DIV_COUNT;
        state_d = S_CFG_WAIT_N;
      end
      S_CFG_WAIT_N: begin
        if (stat_i.div_done) begin
          ctl_o.ld_total = 1'b1;
          state_d = S_CFG_DIV_E;
        end
      end
      S_CFG_DIV_E: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_sel   = fcpa_pkg::DIV_SIZE;
        state_d = S_CFG_WAIT_E;
      end
      S_CFG_WAIT_E: begin
        ctl_o.div_sel = fcpa_pkg::DIV_SIZE;
        if (stat_i.div_done) begin
          ctl_o.ld_eff = 1'b1;
          state_d = S_CFG_SPAN;
        end
      end
      S_CFG_SPAN: begin
        ctl_o.ld_span = 1'b1;
        state_d = S_IDLE;
      end
      S_ALLOC_POP: begin
        if (stat_i.top_zero) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_kind = fcpa_pkg::EMIT_FAIL;
          state_d = S_IDLE;
        end else begin
          ctl_o.pop = 1'b1;
          state_d = S_ALLOC_MUL;
        end
      end
      S_ALLOC_MUL: begin
        ctl_o.mul = 1'b1;
        state_d = S_ALLOC_OUT;
      end
      S_ALLOC_OUT: begin
        ctl_o.emit      = 1'b1;
        ctl_o.emit_kind = fcpa_pkg::EMIT_ALLOC;
        state_d = S_IDLE;
      end
      S_REL_CHK: begin
        ctl_o.div_sel = fcpa_pkg::DIV_INDEX;
        if (stat_i.rel_ok) begin
          ctl_o.div_start = 1'b1;
          state_d = S_REL_WAIT;
        end else begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_kind = fcpa_pkg::EMIT_FAIL;
          state_d = S_IDLE;
        end
      end
      S_REL_WAIT: begin
        ctl_o.div_sel = fcpa_pkg::DIV_INDEX;
        if (stat_i.div_done) begin
          state_d = S_REL_PUSH;
        end
      end
      S_REL_PUSH: begin
        if (stat_i.rem_zero) begin
          ctl_o.push = 1'b1;
          state_d = S_REL_OUT;
        end else begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_kind = fcpa_pkg::EMIT_FAIL;
          state_d = S_IDLE;
        end
      end
      S_REL_OUT: begin
        ctl_o.emit      = 1'b1;
        ctl_o.emit_kind = fcpa_pkg::EMIT_RELEASE;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration is only taken while no operation is running.
  a_cfg_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.cfg_we |-> idle && !start_i)
    else $error("configuration written during an operation");

  // Every accepted write to a known register is followed by a pool rebuild.
  a_cfg_rebuild : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.cfg_we |=> state_q == S_CFG_DIV_N)
    else $error("configuration write without rebuild");

  // A push happens only after a division that left no remainder.
  a_push_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.push |-> stat_i.rem_zero && $past(state_q) == S_REL_WAIT)
    else $error("push without an aligned release");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fixed chunk pool allocator top level.
// Depends on fcpa_pkg and fixed_chunk_pool_allocator_top, and through it on the rest of the block.

module testbench;

  // A register index that no register uses; the block takes the write and drops it.
  localparam logic [1:0] CfgSpareIdx = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Command side. Every input starts at a known value.
  logic           start_i = 1'b0;
  logic           busy_o;
  fcpa_pkg::cmd_t cmd_i = '0;
  logic           done_o;
  fcpa_pkg::res_t res_o;

  // Register write channel.
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  fixed_chunk_pool_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool shadow. This is the testbench's own picture of the allocator: the
  // three registers, the chunk geometry derived from them, and the LIFO of
  // free chunk indices with its low-water mark.
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_base = '0;
  logic [15:0] cfg_size = '0;
  logic [15:0] cfg_chunk = 16'd1;

  logic [7:0]  free_idx [fcpa_pkg::MaxChunks];
  int unsigned free_top;
  int unsigned low_water;
  int unsigned chunk_total;
  int unsigned chunk_bytes;

  // Recompute the geometry and refill the free list. The highest index ends
  // up on top, so the first allocation after a rebuild hands out the last
  // chunk of the pool. A zero chunk size yields an empty pool.
  function automatic void rebuild_free_list();
    int unsigned n;
    n = (cfg_chunk != 0) ? cfg_size / cfg_chunk : 0;
    if (n > fcpa_pkg::MaxChunks) n = fcpa_pkg::MaxChunks;
    chunk_total = n;
    chunk_bytes = (n != 0) ? cfg_size / n : 0;
    for (int unsigned k = 0; k < fcpa_pkg::MaxChunks; k++) begin
      free_idx[k] = (k < n) ? 8'(k) : 8'd0;
    end
    free_top  = n;
    low_water = n;
  endfunction

  // Any write to a known register rebuilds the pool from all three values.
  // The size registers keep only their low sixteen bits.
  function automatic void apply_reg_write(logic [1:0] idx, logic [31:0] data);
    case (idx)
      fcpa_pkg::CFG_POOL_BASE:  cfg_base  = data;
      fcpa_pkg::CFG_POOL_SIZE:  cfg_size  = data[15:0];
      fcpa_pkg::CFG_CHUNK_SIZE: cfg_chunk = data[15:0];
      default: return;
    endcase
    rebuild_free_list();
  endfunction

  // Work out the result word of one accepted command and update the shadow.
  // All address arithmetic wraps at 32 bits, as the hardware does.
  function automatic fcpa_pkg::res_t predict_pool_op(fcpa_pkg::cmd_t c);
    fcpa_pkg::res_t r;
    logic [31:0]    offset;
    int unsigned    span;
    r = '0;
    if (c.mode == fcpa_pkg::MODE_ALLOC) begin
      // An empty free list makes the allocation fail with both counts kept.
      if (free_top != 0) begin
        free_top--;
        r.result_address = cfg_base + 32'(free_idx[free_top] * chunk_bytes);
        r.granted = 1'b1;
        if (low_water > free_top) low_water = free_top;
      end
    end else if (chunk_bytes != 0 && c.chunk_address >= cfg_base) begin
      // A release must land inside the whole chunks (the end address itself
      // is out), sit on a chunk boundary, and find room on the list. A chunk
      // that is already free is not caught and gets pushed a second time.
      offset = c.chunk_address - cfg_base;
      span   = chunk_total * chunk_bytes;
      if (offset < span && (offset % chunk_bytes) == 0 && free_top < chunk_total) begin
        free_idx[free_top] = 8'(offset / chunk_bytes);
        free_top++;
        r.granted = 1'b1;
      end
    end
    r.free_count    = fcpa_pkg::CountWidth'(free_top);
    r.min_free_ever = fcpa_pkg::CountWidth'(low_water);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver. Words waiting to go out sit in cmd_backlog. A word is
  // taken at the edge where start_i is high and busy_o low; that is also the
  // moment its expected result is worked out, so the shadow advances in the
  // same order as the block. While busy_o holds the word off, start_i and
  // cmd_i stay put. Otherwise the driver idles at random with a chance of
  // 17 in 100, except during the quiet stretch.
  // ---------------------------------------------------------------------------
  fcpa_pkg::cmd_t cmd_backlog [$];
  fcpa_pkg::res_t awaited_results [$];
  bit             quiet_run = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      cmd_i   <= '0;
    end else begin
      if (start_i && !busy_o) begin
        awaited_results.push_back(predict_pool_op(cmd_i));
      end
      if (!start_i || !busy_o) begin
        if (cmd_backlog.size() != 0 && (quiet_run || $urandom_range(99) >= 17)) begin
          start_i <= 1'b1;
          cmd_i   <= cmd_backlog.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. A result word is valid for the single cycle done_o is
  // high and is taken at the edge closing that cycle. It is matched against
  // the oldest expected word, one field at a time.
  // ---------------------------------------------------------------------------
  int unsigned    mismatches = 0;
  fcpa_pkg::res_t oldest;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result word with none expected, expected nothing, actual %p",
                 $time, res_o);
        mismatches++;
      end else begin
        oldest = awaited_results.pop_front();
        check_field("result_address", oldest.result_address, res_o.result_address);
        check_field("granted", 32'(oldest.granted), 32'(res_o.granted));
        check_field("free_count", 32'(oldest.free_count), 32'(res_o.free_count));
        check_field("min_free_ever", 32'(oldest.min_free_ever), 32'(res_o.min_free_ever));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Queue one command word. The address of an allocate is don't-care, so it
  // carries random bits to exercise the unused input.
  task automatic queue_cmd(logic mode, logic [31:0] addr);
    fcpa_pkg::cmd_t c;
    c.mode          = mode;
    c.chunk_address = (mode == fcpa_pkg::MODE_ALLOC) ? 32'($urandom()) : addr;
    cmd_backlog.push_back(c);
  endtask

  // Wait until every queued word is taken, every result has come back and
  // the block is idle. Polling on the falling edge keeps clear of the
  // updates the driver and monitor make on the rising edge.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start_i || awaited_results.size() != 0 || busy_o);
  endtask

  // One register write through the valid/ready channel. The shadow takes the
  // write at the edge where the handshake completes.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg_write(idx, data);
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] size, logic [31:0] chunk);
    write_reg(fcpa_pkg::CFG_POOL_BASE, base);
    write_reg(fcpa_pkg::CFG_POOL_SIZE, size);
    write_reg(fcpa_pkg::CFG_CHUNK_SIZE, chunk);
  endtask

  // Random pool geometry. Small pools and modest chunk counts dominate so
  // that the free list runs empty and full often; the unused upper bits of
  // the size words carry junk.
  task automatic configure_random();
    logic [15:0] size;
    logic [15:0] chunk;
    size = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(300));
    case ($urandom_range(3))
      0:       chunk = 16'($urandom_range(65535, 1));
      1:       chunk = 16'($urandom_range(64, 1));
      default: chunk = size / 16'($urandom_range(48, 1));
    endcase
    if (chunk == 0) chunk = 16'd1;
    configure($urandom(), {16'($urandom()), size}, {16'($urandom()), chunk});
  endtask

  // Random traffic for the current geometry. In a pool with chunks, at least
  // half the releases give back a real chunk address; the rest probe the end
  // address, just below the base, off-boundary offsets and arbitrary addresses.
  task automatic fill_random(int unsigned count, int unsigned alloc_pct);
    int unsigned pick;
    int unsigned span;
    logic [31:0] addr;
    span = chunk_total * chunk_bytes;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
      end else begin
        if (pick < 85 && chunk_total != 0) begin
          addr = cfg_base + 32'($urandom_range(chunk_total - 1) * chunk_bytes);
        end else begin
          case ($urandom_range(4))
            0:       addr = $urandom();
            1:       addr = cfg_base + span;
            2:       addr = cfg_base - 32'($urandom_range(16, 1));
            3:       addr = cfg_base + 32'($urandom_range(span)) + 32'd1;
            default: addr = cfg_base + 32'($urandom_range(span));
          endcase
        end
        queue_cmd(fcpa_pkg::MODE_RELEASE, addr);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rebuild_free_list();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Straight out of reset the pool is empty: the allocate fails and no
    // release is accepted.
    queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'h0);
    queue_cmd(fcpa_pkg::MODE_RELEASE, $urandom());
    wait_drained();

    // A write to the spare index must leave the pool alone.
    write_reg(CfgSpareIdx, $urandom());

    // Four chunks of ten bytes at 0x1000. Walk through every release check,
    // a double release, a release into a full list, then allocate past empty.
    configure(32'h0000_1000, 32'd40, 32'd10);
    queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
    queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'h0000_0FFF);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'h0000_1028);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'h0000_1005);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'h0000_1014);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'h0000_1014);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'h0000_1000);
    repeat (5) queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
    wait_drained();

    // Largest pool with a one-byte chunk size: the count saturates, each chunk
    // widens to 255 bytes and the chunk addresses wrap past the top of the address space.
    configure(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd1);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'hFFFF_FFFF);
    queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'hFFFF_FFFF);
    queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
    wait_drained();

    // A zero chunk size leaves no chunks at all.
    write_reg(fcpa_pkg::CFG_CHUNK_SIZE, 32'd0);
    queue_cmd(fcpa_pkg::MODE_ALLOC, '0);
    queue_cmd(fcpa_pkg::MODE_RELEASE, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases, each with its own geometry and its own balance of
    // allocates against releases. Halfway through each phase the sender
    // holds off until every outstanding result is back. Phase five runs
    // without the driver's random idle cycles.
    for (int unsigned phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       configure(32'h0, 32'h0000_FFFF, 32'h0000_FFFF);
        1:       configure($urandom(), 32'h0, 32'($urandom_range(65535, 1)));
        default: configure_random();
      endcase
      quiet_run = (phase == 5);
      fill_random(80, $urandom_range(70, 30));
      wait_drained();
      fill_random(80, $urandom_range(70, 30));
      wait_drained();
    end
    quiet_run = 1'b0;

    // Let any stray result word show up before the verdict.
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
sv/fcpa_pkg.sv
sv/fcpa_div.sv
sv/fcpa_dp.sv
sv/fcpa_ctrl.sv
sv/fixed_chunk_pool_allocator_top.sv
tb/sv/testbench.sv
